// ===== rtl/rlfh_pkg.sv =====
`timescale 1ns / 1ps

package rlfh_pkg;

    localparam int OP_W     = 2;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 4;
    localparam int DEPTH_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOCK    = 2'd0,
        OP_TRYLOCK = 2'd1,
        OP_UNLOCK  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED   = 4'd0,
        ST_QUEUED     = 4'd1,
        ST_BUSY       = 4'd2,
        ST_STILL_HELD = 4'd3,
        ST_FREED      = 4'd4,
        ST_HANDED     = 4'd5,
        ST_QFULL      = 4'd6,
        ST_OVERFLOW   = 4'd7,
        ST_NOT_HELD   = 4'd8,
        ST_DISABLED   = 4'd9
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [TID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [TID_W-1:0]    woken_thread;
        logic [DEPTH_W-1:0]  depth_after;
    } rsp_t;

    localparam logic [2:0] REG_LOCK_ENABLED = 3'd0;

endpackage

// ===== rtl/rlfh_wait_ram.sv =====
`timescale 1ns / 1ps

module rlfh_wait_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/recursive_lock_fifo_handoff.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    req_t: operation, thread_id
// m_        out  m_valid/m_ready    rsp_t: status, woken_valid, woken_thread, depth_after
// apb       in   psel/penable/pready  lock_enabled at byte address 0
//
// Each request is accepted, then executed against the waiter RAM read port,
// whose registered data for the queue head is ready when execute runs.
// A new request is accepted only after the previous one has executed.
// Reset (synchronous, aresetn low) frees the lock and empties the queue.
// A stalled result register holds the execute step; no beat is dropped.

module recursive_lock_fifo_handoff
    import rlfh_pkg::*;
#(
    parameter int WAIT_DEPTH     = 16,
    parameter int THREAD_ID_BITS = 8,
    parameter int DEPTH_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WAIT_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_EXEC = 2'b10
    } phase_t;

    phase_t phase_reg, phase_next;

    logic                      en_reg;
    logic                      held_reg, held_next;
    logic [THREAD_ID_BITS-1:0] owner_reg, owner_next;
    logic [DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic [PTR_W-1:0]          head_reg, head_next;
    logic [PTR_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    req_t                      req_reg;
    rsp_t                      out_reg, out_next;
    logic                      m_valid_reg, m_valid_next;

    logic                      go;
    logic                      q_wr;
    logic [THREAD_ID_BITS-1:0] q_rd_data;
    logic [15:0]               tid_wide;
    logic [THREAD_ID_BITS-1:0] tid;
    logic [15:0]               woken_wide;
    logic [31:0]               depth_wide;
    logic [DEPTH_BITS-1:0]     depth_dec;
    status_t                   status;
    logic                      woken;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_LOCK_ENABLED) ? {31'b0, en_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_LOCK_ENABLED) begin
            en_reg <= pwdata[0];
        end
    end

    rlfh_wait_ram #(
        .DEPTH  (WAIT_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (THREAD_ID_BITS)
    ) u_wait_ram (
        .aclk    (aclk),
        .wr_en   (q_wr),
        .wr_addr (tail_reg),
        .wr_data (tid),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    assign s_ready = (phase_reg == PH_IDLE);
    assign go      = (phase_reg == PH_EXEC) && (!m_valid_reg || m_ready);

    assign tid_wide = 16'(req_reg.thread_id);
    assign tid      = tid_wide[THREAD_ID_BITS-1:0];
    assign depth_dec = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

    always_comb begin
        held_next  = held_reg;
        owner_next = owner_reg;
        depth_next = depth_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        q_wr       = 1'b0;
        woken      = 1'b0;
        status     = ST_BUSY;

        if (!en_reg) begin
            status = (req_reg.operation == OP_TRYLOCK) ? ST_ACQUIRED : ST_DISABLED;
        end else begin
            case (req_reg.operation)
                OP_LOCK, OP_TRYLOCK: begin
                    if (!held_reg) begin
                        held_next  = 1'b1;
                        owner_next = tid;
                        depth_next = DEPTH_BITS'(1);
                        status     = ST_ACQUIRED;
                    end else if (owner_reg == tid) begin
                        if (depth_reg == '1) begin
                            status = ST_OVERFLOW;
                        end else begin
                            depth_next = depth_reg + 1'b1;
                            status     = ST_ACQUIRED;
                        end
                    end else if (req_reg.operation == OP_TRYLOCK) begin
                        status = ST_BUSY;
                    end else if (count_reg >= CNT_FULL) begin
                        status = ST_QFULL;
                    end else begin
                        q_wr       = 1'b1;
                        tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        status     = ST_QUEUED;
                    end
                end
                OP_UNLOCK: begin
                    if (!held_reg) begin
                        status = ST_NOT_HELD;
                    end else if (depth_dec != '0) begin
                        depth_next = depth_dec;
                        status     = ST_STILL_HELD;
                    end else if (count_reg != '0) begin
                        owner_next = q_rd_data;
                        head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        depth_next = DEPTH_BITS'(1);
                        woken      = 1'b1;
                        status     = ST_HANDED;
                    end else begin
                        held_next  = 1'b0;
                        depth_next = depth_dec;
                        status     = ST_FREED;
                    end
                end
                default: begin
                    status = ST_BUSY;
                end
            endcase
        end

        if (!go) begin
            q_wr = 1'b0;
        end
    end

    assign woken_wide = woken ? 16'(owner_next) : 16'b0;
    assign depth_wide = 32'(depth_next);

    always_comb begin
        out_next.status       = status;
        out_next.woken_valid  = woken;
        out_next.woken_thread = woken_wide[TID_W-1:0];
        out_next.depth_after  = depth_wide[DEPTH_W-1:0];
    end

    always_comb begin
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (phase_reg)
            PH_IDLE: begin
                if (s_valid) begin
                    phase_next = PH_EXEC;
                end
            end
            PH_EXEC: begin
                if (go) begin
                    phase_next   = PH_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= 1'b0;
            owner_reg   <= '0;
            depth_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (go) begin
                held_reg  <= held_next;
                owner_reg <= owner_next;
                depth_reg <= depth_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (go) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("waiter count beyond queue depth");

    a_held_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg == (depth_reg != '0))
        else $error("held flag and nesting depth disagree");

    a_woken_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.woken_valid == (m_data.status == ST_HANDED)))
        else $error("woken beat without hand-off status");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (phase_reg == PH_EXEC && !s_ready))
        else $error("accepted beat did not enter execute");

endmodule

// ===== bench/lock_checker.sv =====
`timescale 1ns / 1ps

module lock_checker
    import rlfh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  req_t        s_data,

    input  logic        m_valid,
    input  logic        m_ready,
    input  rsp_t        m_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    output int          fails,
    output int          outstanding
);

    localparam int WAIT_SLOTS = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = {DEPTH_W{1'b1}};

    logic             lock_en;
    logic             held;
    logic [TID_W-1:0] owner;
    logic [DEPTH_W-1:0] depth;
    logic [TID_W-1:0] waiters [WAIT_SLOTS];
    logic [3:0]       wait_head;
    logic [3:0]       wait_tail;
    logic [4:0]       wait_count;

    rsp_t owed_replies [$];
    int   mismatch_total = 0;
    int   owed_total = 0;

    assign fails = mismatch_total;
    assign outstanding = owed_total;

    task automatic grant_or_nest(input logic [TID_W-1:0] tid, output status_t st);
        if (!held) begin
            held = 1'b1;
            owner = tid;
            depth = DEPTH_W'(1);
            st = ST_ACQUIRED;
        end else if (depth >= DEPTH_TOP) begin
            st = ST_OVERFLOW;
        end else begin
            depth = depth + 1'b1;
            st = ST_ACQUIRED;
        end
    endtask

    task automatic resolve_request(input req_t r, output rsp_t o);
        logic [TID_W-1:0] tid;
        status_t st;
        tid = r.thread_id;
        o = '0;
        if (!lock_en) begin
            st = (op_t'(r.operation) == OP_TRYLOCK) ? ST_ACQUIRED : ST_DISABLED;
        end else begin
            case (op_t'(r.operation))
                OP_LOCK: begin
                    if (!held || owner == tid) begin
                        grant_or_nest(tid, st);
                    end else if (wait_count >= WAIT_SLOTS) begin
                        st = ST_QFULL;
                    end else begin
                        waiters[wait_tail] = tid;
                        wait_tail = wait_tail + 1'b1;
                        wait_count = wait_count + 1'b1;
                        st = ST_QUEUED;
                    end
                end
                OP_TRYLOCK: begin
                    if (!held || owner == tid) begin
                        grant_or_nest(tid, st);
                    end else begin
                        st = ST_BUSY;
                    end
                end
                OP_UNLOCK: begin
                    if (!held) begin
                        st = ST_NOT_HELD;
                    end else begin
                        if (depth != 0) depth = depth - 1'b1;
                        if (depth != 0) begin
                            st = ST_STILL_HELD;
                        end else if (wait_count != 0) begin
                            owner = waiters[wait_head];
                            wait_head = wait_head + 1'b1;
                            wait_count = wait_count - 1'b1;
                            depth = DEPTH_W'(1);
                            o.woken_valid = 1'b1;
                            o.woken_thread = owner;
                            st = ST_HANDED;
                        end else begin
                            held = 1'b0;
                            st = ST_FREED;
                        end
                    end
                end
                default: begin
                    st = ST_BUSY;
                end
            endcase
        end
        o.status = st;
        o.depth_after = depth;
    endtask

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            lock_en = 1'b0;
            held = 1'b0;
            owner = '0;
            depth = '0;
            wait_head = '0;
            wait_tail = '0;
            wait_count = '0;
            owed_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_replies.size() == 0) begin
                    $error("unexpected result beat %h", m_data);
                    mismatch_total++;
                end else begin
                    want = owed_replies.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        mismatch_total++;
                    end
                    if (m_data.woken_valid !== want.woken_valid) begin
                        $error("woken_valid: expected %0d, got %0d",
                               want.woken_valid, m_data.woken_valid);
                        mismatch_total++;
                    end
                    if (m_data.woken_thread !== want.woken_thread) begin
                        $error("woken_thread: expected %0d, got %0d",
                               want.woken_thread, m_data.woken_thread);
                        mismatch_total++;
                    end
                    if (m_data.depth_after !== want.depth_after) begin
                        $error("depth_after: expected %0d, got %0d",
                               want.depth_after, m_data.depth_after);
                        mismatch_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                resolve_request(s_data, want);
                owed_replies.push_back(want);
            end
            if (psel && penable && pready && paddr == REG_LOCK_ENABLED) begin
                if (pwrite) begin
                    lock_en = pwdata[0];
                end else if (prdata !== {31'b0, lock_en}) begin
                    $error("lock_enabled: expected %0d, got %0d", lock_en, prdata);
                    mismatch_total++;
                end
            end
        end
        owed_total = owed_replies.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rlfh_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rsp_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fails;
    int outstanding;

    int burst_left = 0;
    bit gaps_on = 1'b1;
    int rx_mode = 0;
    int rx_left = 0;

    recursive_lock_fifo_handoff dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lock_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((rx_left % 8) < 3);
        endcase
    end

    task automatic send(input op_t op, input logic [TID_W-1:0] tid);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) gap = $urandom_range(0, 5);
        end
        burst_left--;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{operation: op, thread_id: tid};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_enable(input logic en);
        logic [31:0] word;
        drain();
        word = $urandom;
        word[0] = en;
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_LOCK_ENABLED;
        pwdata <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [TID_W-1:0] pool [4];
        logic [TID_W-1:0] tid;
        logic [TID_W-1:0] hog;
        op_t op;
        int r;
        int unlock_w;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_LOCK_ENABLED;
        pwdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_enable(1'b0);
        send(OP_LOCK, 8'h00);
        send(OP_TRYLOCK, 8'hFF);
        send(OP_UNLOCK, 8'h5A);
        send(OP_NONE, 8'hA5);

        set_enable(1'b1);
        send(OP_UNLOCK, 8'h3C);
        send(OP_NONE, 8'hC3);
        send(OP_TRYLOCK, 8'hAA);
        send(OP_LOCK, 8'hAA);
        send(OP_TRYLOCK, 8'h55);
        send(OP_LOCK, 8'h55);
        send(OP_UNLOCK, 8'h11);
        send(OP_UNLOCK, 8'hAA);
        send(OP_UNLOCK, 8'h55);
        send(OP_TRYLOCK, 8'h55);
        send(OP_LOCK, 8'h55);
        for (int i = 0; i < 16; i++) begin
            tid = (i == 15) ? 8'h0F : {i[3:0], ~i[3:0]};
            send(OP_LOCK, tid);
        end
        send(OP_LOCK, 8'h00);
        send(OP_TRYLOCK, 8'h0F);
        repeat (18) send(OP_UNLOCK, 8'(($urandom_range(0, 255))));

        gaps_on = 1'b0;
        hog = 8'($urandom_range(0, 255));
        send(OP_TRYLOCK, hog);
        for (int i = 1; i < 24; i++) begin
            send((i % 2) ? OP_LOCK : OP_TRYLOCK, hog);
        end
        send(OP_LOCK, hog);
        send(OP_TRYLOCK, hog);
        send(OP_LOCK, ~hog);
        send(OP_TRYLOCK, ~hog);
        repeat (26) send(OP_UNLOCK, hog);
        send(OP_UNLOCK, ~hog);
        gaps_on = 1'b1;

        for (int phase = 0; phase < 7; phase++) begin
            set_enable(phase != 2 && phase != 5);
            for (int k = 0; k < 4; k++) pool[k] = 8'($urandom_range(0, 255));
            unlock_w = $urandom_range(30, 40);
            for (int n = 0; n < 235; n++) begin
                if (phase == 3 && n == 120) drain();
                r = $urandom_range(0, 99);
                if (r < 38) op = OP_LOCK;
                else if (r < 56) op = OP_TRYLOCK;
                else if (r < 56 + unlock_w) op = OP_UNLOCK;
                else op = OP_NONE;
                if ($urandom_range(0, 99) < 85) tid = pool[2'($urandom_range(0, 3))];
                else tid = 8'($urandom_range(0, 255));
                send(op, tid);
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (fails == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
